>>> design/body_frame_wind_drag_force_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the body frame wind drag force core
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BODY_FRAME_WIND_DRAG_FORCE_CORE_MACROS_SVH
`define BODY_FRAME_WIND_DRAG_FORCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define BFWD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The condition must never be true.
`define BFWD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BFWD_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define BFWD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> design/bfwd_pkg.sv
// ----------------------------------------------------------------------------
// bfwd_pkg
// Types and fixed-point constants shared by the wind drag force core.
// ----------------------------------------------------------------------------
package bfwd_pkg;

  localparam int Q_W      = 16;
  localparam int V_W      = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int REL_W    = 17;
  localparam int ROT_W    = 32;
  localparam int PROD_W   = 49;
  localparam int BODY_SUM_W = 51;
  localparam int BODY_W   = 21;
  localparam int SQ_W     = 42;
  localparam int RAD_W    = 44;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int SQRT_BITS_PER_STAGE = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_BITS_PER_STAGE;
  localparam int C_W      = 32;
  localparam int RC_W     = 32;
  localparam int CA_W     = 49;
  localparam int C_SHIFT  = 17;
  localparam int P_W      = ROOT_W + BODY_W;
  localparam int LO_W     = 16;
  localparam int A_W      = C_W + P_W - LO_W;
  localparam int B_W      = C_W + LO_W;
  localparam int A_SHIFT  = 12;
  localparam int LOW_W    = 49;
  localparam int MAG_W    = 48;
  localparam int FRAC_ROT = 28;
  localparam int F_W      = 32;
  localparam int WPROD_W  = 64;
  localparam int WSUM_W   = 65;
  localparam int LATENCY  = SQRT_STAGES + 12;

  localparam logic signed [Q_W-1:0] Q_MAX = 16'sd16384;
  localparam logic signed [Q_W-1:0] Q_MIN = -16'sd16384;
  localparam logic [F_W-1:0] F_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [F_W-1:0] F_NEG_MIN = 32'h8000_0000;

  localparam logic [CFG_W-1:0] RHO_RESET   = 16'd5018;
  localparam logic [CFG_W-1:0] FRONT_RESET = 16'd1565;
  localparam logic [CFG_W-1:0] SIDE_RESET  = 16'd3148;
  localparam logic [CFG_W-1:0] CD_RESET    = 16'd4506;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIND_EAST    = 3'd0,
    CFG_WIND_NORTH   = 3'd1,
    CFG_WIND_UP      = 3'd2,
    CFG_AIR_DENSITY  = 3'd3,
    CFG_FRONTAL_AREA = 3'd4,
    CFG_SIDE_AREA    = 3'd5,
    CFG_DRAG_COEFF   = 3'd6
  } bfwd_cfg_idx_e;

  typedef struct packed {
    logic                  paused;
    logic signed [Q_W-1:0] orient_w;
    logic signed [Q_W-1:0] orient_x;
    logic signed [Q_W-1:0] orient_y;
    logic signed [Q_W-1:0] orient_z;
    logic signed [V_W-1:0] vel_east;
    logic signed [V_W-1:0] vel_north;
    logic signed [V_W-1:0] vel_up;
  } bfwd_in_t;

  typedef struct packed {
    logic signed [F_W-1:0] force_east;
    logic signed [F_W-1:0] force_north;
    logic signed [F_W-1:0] force_up;
    logic                  clipped;
  } bfwd_out_t;

  typedef struct packed {
    logic signed [BODY_W-1:0] bx;
    logic signed [BODY_W-1:0] by;
    logic signed [ROT_W-1:0]  r00;
    logic signed [ROT_W-1:0]  r01;
    logic signed [ROT_W-1:0]  r10;
    logic signed [ROT_W-1:0]  r11;
    logic signed [ROT_W-1:0]  r20;
    logic signed [ROT_W-1:0]  r21;
    logic [C_W-1:0]           cf;
    logic [C_W-1:0]           cs;
  } bfwd_side_t;

  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } bfwd_sqrt_res_t;

endpackage

>>> design/bfwd_isqrt.sv
// ----------------------------------------------------------------------------
// bfwd_isqrt
// Pipelined digit-by-digit integer square root, two root bits per stage.
// ----------------------------------------------------------------------------
module bfwd_isqrt
  import bfwd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RAD_W-1:0] rad_i,
  output bfwd_sqrt_res_t   res_o
);

  logic              valid_q [SQRT_STAGES];
  logic [RAD_W-1:0]  rad_q   [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q   [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic              src_valid;
    logic [RAD_W-1:0]  src_rad;
    logic [ROOT_W-1:0] src_root;
    logic [REM_W-1:0]  src_rem;
    logic [RAD_W-1:0]  rad_d;
    logic [ROOT_W-1:0] root_d;
    logic [REM_W-1:0]  rem_d;

    if (s == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_rad   = rad_i;
      assign src_root  = '0;
      assign src_rem   = '0;
    end else begin : g_next
      assign src_valid = valid_q[s-1];
      assign src_rad   = rad_q[s-1];
      assign src_root  = root_q[s-1];
      assign src_rem   = rem_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      rad_d  = src_rad;
      root_d = src_root;
      rem_d  = src_rem;
      for (int k = 0; k < SQRT_BITS_PER_STAGE; k++) begin
        rem_t = {rem_d[REM_W-3:0], rad_d[RAD_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, root_d, 2'b01};
        if (rem_t >= trial) begin
          rem_d  = rem_t - trial;
          root_d = {root_d[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_t;
          root_d = {root_d[ROOT_W-2:0], 1'b0};
        end
        rad_d = {rad_d[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_d;
      root_q[s] <= root_d;
      rem_q[s]  <= rem_d;
    end
  end

  assign res_o.valid = valid_q[SQRT_STAGES-1];
  assign res_o.root  = root_q[SQRT_STAGES-1];
  assign res_o.rem   = rem_q[SQRT_STAGES-1];

endmodule

>>> design/body_frame_wind_drag_force_core.sv
// ----------------------------------------------------------------------------
// body_frame_wind_drag_force_core
// Quadratic aerodynamic drag on a hull, worked out in the body frame.
// ----------------------------------------------------------------------------
// An item (orientation quaternion and world velocity) is taken at every clock
// edge at which start is high; busy stays low, so one item may follow another
// in every cycle. A result appears on res_o for exactly one cycle, marked by
// res_valid_o. The receiver cannot hold results off, so it must take each
// item in the cycle it is shown. A paused item travels down the pipeline as
// a bubble and gives no result. The square root resolves two bits of the
// 22-bit speed per stage over eleven stages, with twelve arithmetic stages
// around it. Configuration registers are written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i and take effect on the next item; they should only be
// written while no item is in flight.
// ----------------------------------------------------------------------------
`include "body_frame_wind_drag_force_core_macros.svh"

module body_frame_wind_drag_force_core
  import bfwd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bfwd_in_t             in_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 res_valid_o,
  output bfwd_out_t            res_o
);

  // The rounding of a body-frame sum of products back to Q8.8, halves away
  // from zero.
  function automatic logic signed [BODY_W-1:0] rnd_body(
    input logic signed [BODY_SUM_W-1:0] s
  );
    logic [BODY_SUM_W-1:0] mag;
    logic [BODY_SUM_W-1:0] m;
    mag = s[BODY_SUM_W-1] ? BODY_SUM_W'(-s) : BODY_SUM_W'(s);
    m   = (mag + (BODY_SUM_W'(1) << (FRAC_ROT - 1))) >> FRAC_ROT;
    return s[BODY_SUM_W-1] ? BODY_W'(-m) : BODY_W'(m);
  endfunction

  // World force rounding and saturation; the top bit returned is the clip flag.
  function automatic logic [F_W:0] rnd_sat_world(input logic signed [WSUM_W-1:0] s);
    logic                         neg;
    logic [WSUM_W-1:0]            mag;
    logic [WSUM_W-1:0]            tmp;
    logic [WSUM_W-FRAC_ROT-1:0]   m;
    neg = s[WSUM_W-1];
    mag = neg ? WSUM_W'(-s) : WSUM_W'(s);
    tmp = (mag + (WSUM_W'(1) << (FRAC_ROT - 1))) >> FRAC_ROT;
    m   = tmp[WSUM_W-FRAC_ROT-1:0];
    if (!neg && (m > (WSUM_W-FRAC_ROT)'(F_POS_MAX))) begin
      return {1'b1, F_POS_MAX};
    end
    if (neg && (m > (WSUM_W-FRAC_ROT)'(F_NEG_MIN))) begin
      return {1'b1, F_NEG_MIN};
    end
    return {1'b0, (neg ? F_W'(-m) : F_W'(m))};
  endfunction

  function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W-1:0] v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [CFG_W-1:0] wind_east_q, wind_north_q, wind_up_q;
  logic [CFG_W-1:0] rho_q, front_q, side_q, cd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wind_east_q  <= '0;
      wind_north_q <= '0;
      wind_up_q    <= '0;
      rho_q        <= RHO_RESET;
      front_q      <= FRONT_RESET;
      side_q       <= SIDE_RESET;
      cd_q         <= CD_RESET;
    end else if (cfg_we_i) begin
      unique case (bfwd_cfg_idx_e'(cfg_idx_i))
        CFG_WIND_EAST:    wind_east_q  <= cfg_wdata_i;
        CFG_WIND_NORTH:   wind_north_q <= cfg_wdata_i;
        CFG_WIND_UP:      wind_up_q    <= cfg_wdata_i;
        CFG_AIR_DENSITY:  rho_q        <= cfg_wdata_i;
        CFG_FRONTAL_AREA: front_q      <= cfg_wdata_i;
        CFG_SIDE_AREA:    side_q       <= cfg_wdata_i;
        CFG_DRAG_COEFF:   cd_q         <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The pipeline never stalls, so it is never busy.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 0: clamp the quaternion, form the air-relative velocity and the
  // product of density and drag coefficient.
  // --------------------------------------------------------------------------
  logic v0_d;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;
  logic signed [Q_W-1:0]   qw0_q, qx0_q, qy0_q, qz0_q;
  logic signed [REL_W-1:0] rx0_q, ry0_q, rz0_q;
  logic [RC_W-1:0]         rc0_q;

  assign v0_d = start && !busy && !in_i.paused;

  always_ff @(posedge clk_i) begin
    qw0_q <= clamp_q(in_i.orient_w);
    qx0_q <= clamp_q(in_i.orient_x);
    qy0_q <= clamp_q(in_i.orient_y);
    qz0_q <= clamp_q(in_i.orient_z);
    rx0_q <= REL_W'(wind_east_q) - REL_W'(in_i.vel_east);
    ry0_q <= REL_W'(wind_north_q) - REL_W'(in_i.vel_north);
    rz0_q <= REL_W'(wind_up_q) - REL_W'(in_i.vel_up);
    rc0_q <= rho_q * cd_q;
  end

  // --------------------------------------------------------------------------
  // Stage 1: rotation matrix entries in Q.28 and the two drag constants in Q.20.
  // --------------------------------------------------------------------------
  bfwd_side_t s1_q, s2_q, s3_q, s4_q, s5_q;
  logic signed [REL_W-1:0] rx1_q, ry1_q, rz1_q;
  logic [CA_W-1:0] caf, cas;

  always_comb begin
    caf = CA_W'(rc0_q * front_q) + (CA_W'(1) << (C_SHIFT - 1));
    cas = CA_W'(rc0_q * side_q) + (CA_W'(1) << (C_SHIFT - 1));
  end

  always_ff @(posedge clk_i) begin
    s1_q.bx  <= '0;
    s1_q.by  <= '0;
    s1_q.r00 <= qw0_q * qw0_q + qx0_q * qx0_q - qy0_q * qy0_q - qz0_q * qz0_q;
    s1_q.r01 <= (qx0_q * qy0_q - qw0_q * qz0_q) <<< 1;
    s1_q.r10 <= (qx0_q * qy0_q + qw0_q * qz0_q) <<< 1;
    s1_q.r11 <= qw0_q * qw0_q - qx0_q * qx0_q + qy0_q * qy0_q - qz0_q * qz0_q;
    s1_q.r20 <= (qx0_q * qz0_q - qw0_q * qy0_q) <<< 1;
    s1_q.r21 <= (qy0_q * qz0_q + qw0_q * qx0_q) <<< 1;
    s1_q.cf  <= C_W'(caf >> C_SHIFT);
    s1_q.cs  <= C_W'(cas >> C_SHIFT);
    rx1_q    <= rx0_q;
    ry1_q    <= ry0_q;
    rz1_q    <= rz0_q;
  end

  // --------------------------------------------------------------------------
  // Stage 2: products for the rotation into the body frame (transpose).
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] m00_q, m10_q, m20_q, m01_q, m11_q, m21_q;

  always_ff @(posedge clk_i) begin
    m00_q <= s1_q.r00 * rx1_q;
    m10_q <= s1_q.r10 * ry1_q;
    m20_q <= s1_q.r20 * rz1_q;
    m01_q <= s1_q.r01 * rx1_q;
    m11_q <= s1_q.r11 * ry1_q;
    m21_q <= s1_q.r21 * rz1_q;
    s2_q  <= s1_q;
  end

  // --------------------------------------------------------------------------
  // Stage 3: body velocity rounded to Q8.8.
  // --------------------------------------------------------------------------
  logic signed [BODY_SUM_W-1:0] bsum_x, bsum_y;
  bfwd_side_t                   s3_d;

  always_comb begin
    bsum_x = BODY_SUM_W'(m00_q) + BODY_SUM_W'(m10_q) + BODY_SUM_W'(m20_q);
    bsum_y = BODY_SUM_W'(m01_q) + BODY_SUM_W'(m11_q) + BODY_SUM_W'(m21_q);
    s3_d    = s2_q;
    s3_d.bx = rnd_body(bsum_x);
    s3_d.by = rnd_body(bsum_y);
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: squares and the radicand of the horizontal speed.
  // --------------------------------------------------------------------------
  logic signed [SQ_W-1:0] sqx_q, sqy_q;
  logic [RAD_W-1:0]       rad5_q;

  always_ff @(posedge clk_i) begin
    sqx_q  <= s3_q.bx * s3_q.bx;
    sqy_q  <= s3_q.by * s3_q.by;
    s4_q   <= s3_q;
    rad5_q <= RAD_W'(unsigned'(sqx_q)) + RAD_W'(unsigned'(sqy_q));
    s5_q   <= s4_q;
  end

  // --------------------------------------------------------------------------
  // Square root, with the side data delayed to match.
  // --------------------------------------------------------------------------
  bfwd_sqrt_res_t sq_res;
  bfwd_side_t     sd_q   [SQRT_STAGES];
  logic           sd_v_q [SQRT_STAGES];

  bfwd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (rad5_q),
    .res_o   (sq_res)
  );

  always_ff @(posedge clk_i) begin
    sd_q[0] <= s5_q;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      sd_q[k] <= sd_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQRT_STAGES; k++) begin
        sd_v_q[k] <= 1'b0;
      end
    end else begin
      sd_v_q[0] <= v5_q;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sd_v_q[k] <= sd_v_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: round the root to nearest; a remainder above the root rounds up.
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] speed6_q;
  bfwd_side_t        s6_q, s7_q, s8_q, s9_q;

  always_ff @(posedge clk_i) begin
    speed6_q <= sq_res.root +
                ROOT_W'(sq_res.rem > REM_W'(sq_res.root));
    s6_q     <= sd_q[SQRT_STAGES-1];
  end

  // --------------------------------------------------------------------------
  // Stages 7 to 9: drag magnitude c * speed * |component| in Q.8, with the
  // wide product split into a high and a low partial product.
  // --------------------------------------------------------------------------
  logic [BODY_W-1:0] magx, magy;
  logic [P_W-1:0]    px7_q, py7_q;
  logic [A_W-1:0]    pax8_q, pay8_q;
  logic [B_W-1:0]    pbx8_q, pby8_q;

  always_comb begin
    magx = s6_q.bx[BODY_W-1] ? BODY_W'(-s6_q.bx) : BODY_W'(s6_q.bx);
    magy = s6_q.by[BODY_W-1] ? BODY_W'(-s6_q.by) : BODY_W'(s6_q.by);
  end

  always_ff @(posedge clk_i) begin
    px7_q  <= speed6_q * magx;
    py7_q  <= speed6_q * magy;
    s7_q   <= s6_q;
    pax8_q <= s7_q.cf * px7_q[P_W-1:LO_W];
    pbx8_q <= s7_q.cf * px7_q[LO_W-1:0];
    pay8_q <= s7_q.cs * py7_q[P_W-1:LO_W];
    pby8_q <= s7_q.cs * py7_q[LO_W-1:0];
    s8_q   <= s7_q;
  end

  // Combine the partial products and saturate a body force to 32 bits.
  function automatic logic [F_W:0] drag_finish(
    input logic [A_W-1:0] a,
    input logic [B_W-1:0] b,
    input logic           neg
  );
    logic [LOW_W-1:0] low;
    logic [MAG_W-1:0] mag;
    logic [F_W-1:0]   m32;
    low = LOW_W'({a[A_SHIFT-1:0], {LO_W{1'b0}}}) + LOW_W'(b) +
          (LOW_W'(1) << (FRAC_ROT - 1));
    mag = MAG_W'(a[A_W-1:A_SHIFT]) + MAG_W'(low[LOW_W-1:FRAC_ROT]);
    if (mag > MAG_W'(F_POS_MAX)) begin
      m32 = neg ? F_NEG_MIN : F_POS_MAX;
      return {1'b1, (neg ? F_W'(-m32) : m32)};
    end
    m32 = mag[F_W-1:0];
    return {1'b0, (neg ? F_W'(-m32) : m32)};
  endfunction

  logic [F_W:0] dfx, dfy;
  logic signed [F_W-1:0] fx9_q, fy9_q;
  logic clip9_q;

  assign dfx = drag_finish(pax8_q, pbx8_q, s8_q.bx[BODY_W-1]);
  assign dfy = drag_finish(pay8_q, pby8_q, s8_q.by[BODY_W-1]);

  always_ff @(posedge clk_i) begin
    fx9_q   <= dfx[F_W-1:0];
    fy9_q   <= dfy[F_W-1:0];
    clip9_q <= dfx[F_W] | dfy[F_W];
    s9_q    <= s8_q;
  end

  // --------------------------------------------------------------------------
  // Stages 10 and 11: rotate the body force back to world axes.
  // --------------------------------------------------------------------------
  logic signed [WPROD_W-1:0] e0_q, e1_q, n0_q, n1_q, u0_q, u1_q;
  logic clip10_q;
  logic [F_W:0] we, wn, wu;
  bfwd_out_t res_q;

  always_ff @(posedge clk_i) begin
    e0_q     <= s9_q.r00 * fx9_q;
    e1_q     <= s9_q.r01 * fy9_q;
    n0_q     <= s9_q.r10 * fx9_q;
    n1_q     <= s9_q.r11 * fy9_q;
    u0_q     <= s9_q.r20 * fx9_q;
    u1_q     <= s9_q.r21 * fy9_q;
    clip10_q <= clip9_q;
  end

  assign we = rnd_sat_world(WSUM_W'(e0_q) + WSUM_W'(e1_q));
  assign wn = rnd_sat_world(WSUM_W'(n0_q) + WSUM_W'(n1_q));
  assign wu = rnd_sat_world(WSUM_W'(u0_q) + WSUM_W'(u1_q));

  always_ff @(posedge clk_i) begin
    res_q.force_east  <= we[F_W-1:0];
    res_q.force_north <= wn[F_W-1:0];
    res_q.force_up    <= wu[F_W-1:0];
    res_q.clipped     <= clip10_q | we[F_W] | wn[F_W] | wu[F_W];
  end

  // Valid bits travelling with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      v0_q  <= v0_d;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= sq_res.valid;
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
    end
  end

  assign res_valid_o = v11_q;
  assign res_o       = res_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BFWD_ASSERT_IMPLIES(a_result_origin, res_valid_o, $past(v0_d, LATENCY), "orphan result")
  `BFWD_ASSERT_NEVER(a_sqrt_aligned, sq_res.valid != sd_v_q[SQRT_STAGES-1], "root out of step")

endmodule
